@@ design/bldim_pkg.sv @@
// Shared types, constants, built-in breakpoint tables and microprogram of the dim alpha block.
package bldim_pkg;

    // Field widths fixed by the item and register layout.
    localparam int LEVEL_BITS      = 12;
    localparam int ALPHA_W         = 8;
    localparam int ENTRY_IDX_W     = 5;
    localparam int ENTRIES_W       = 6;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 12;
    localparam int TABLE_DEPTH_DEF = 32;
    localparam int BP_W            = LEVEL_BITS + ALPHA_W;

    // Built-in tables.
    localparam int DEFAULT_COUNT = 20;
    localparam int ALT_COUNT     = 23;
    localparam int TAB_IDX_W     = 5;

    // Divider runs one quotient bit per step over the eight alpha bits.
    localparam int DCNT_W = 3;
    localparam int STEP_W = 4;

    typedef logic [LEVEL_BITS-1:0] t_level;
    typedef logic [ALPHA_W-1:0]    t_alpha;
    typedef logic [STEP_W-1:0]     t_step;

    typedef struct packed {
        t_level lvl;
        t_alpha a;
    } t_bp;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OVERRIDE  = 3'd0,
        CFG_BOOST     = 3'd1,
        CFG_PRIMARY   = 3'd2,
        CFG_FIX_PEND  = 3'd3,
        CFG_FIX_LEVEL = 3'd4,
        CFG_LAST      = 3'd5,
        CFG_ENTRIES   = 3'd6,
        CFG_DITHER    = 3'd7
    } t_cfg;

    // Table selected for a walk.
    typedef enum logic [1:0] {
        TAB_ALT  = 2'd0,
        TAB_DEF  = 2'd1,
        TAB_CUST = 2'd2
    } t_tab;

    // Datapath operations of one control word.
    typedef enum logic [3:0] {
        OP_NOP     = 4'd0,
        OP_IDLE    = 4'd1,
        OP_LOAD    = 4'd2,
        OP_READ    = 4'd3,
        OP_CHECK   = 4'd4,
        OP_MUL     = 4'd5,
        OP_DIVINIT = 4'd6,
        OP_DIV     = 4'd7,
        OP_FIN     = 4'd8,
        OP_EMIT    = 4'd9,
        OP_WRITE   = 4'd10
    } t_op;

    // Jump conditions.
    typedef enum logic [3:0] {
        JC_NEVER     = 4'd0,
        JC_ALWAYS    = 4'd1,
        JC_NO_ACCEPT = 4'd2,
        JC_WRITE     = 4'd3,
        JC_DIRECT    = 4'd4,
        JC_MORE      = 4'd5,
        JC_CLAMP     = 4'd6,
        JC_DIV_MORE  = 4'd7,
        JC_OUT_BUSY  = 4'd8
    } t_cond;

    // Program addresses.
    localparam t_step STEP_IDLE    = 4'd0;
    localparam t_step STEP_DECODE  = 4'd1;
    localparam t_step STEP_LOAD    = 4'd2;
    localparam t_step STEP_READ    = 4'd3;
    localparam t_step STEP_CHECK   = 4'd4;
    localparam t_step STEP_CLAMP   = 4'd5;
    localparam t_step STEP_MUL     = 4'd6;
    localparam t_step STEP_DIVINIT = 4'd7;
    localparam t_step STEP_DIV     = 4'd8;
    localparam t_step STEP_FIN     = 4'd9;
    localparam t_step STEP_EMIT    = 4'd10;
    localparam t_step STEP_RETURN  = 4'd11;
    localparam t_step STEP_WRITE   = 4'd12;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_step target;
    } t_uword;

    // Control from sequencer to datapath.
    typedef struct packed {
        t_op  op;
        logic in_ready;
    } t_ctrl;

    // Status flags from datapath to sequencer.
    typedef struct packed {
        logic accept;
        logic is_write;
        logic direct;
        logic more;
        logic clamp;
        logic div_more;
        logic out_busy;
    } t_stat;

    // Microprogram: a taken jump goes to target, otherwise to the next step.
    function automatic t_uword ucode(input t_step pc);
        unique case (pc)
            STEP_IDLE:    ucode = '{op: OP_IDLE,    cond: JC_NO_ACCEPT, target: STEP_IDLE};
            STEP_DECODE:  ucode = '{op: OP_NOP,     cond: JC_WRITE,     target: STEP_WRITE};
            STEP_LOAD:    ucode = '{op: OP_LOAD,    cond: JC_DIRECT,    target: STEP_EMIT};
            STEP_READ:    ucode = '{op: OP_READ,    cond: JC_NEVER,     target: STEP_IDLE};
            STEP_CHECK:   ucode = '{op: OP_CHECK,   cond: JC_MORE,      target: STEP_READ};
            STEP_CLAMP:   ucode = '{op: OP_NOP,     cond: JC_CLAMP,     target: STEP_EMIT};
            STEP_MUL:     ucode = '{op: OP_MUL,     cond: JC_NEVER,     target: STEP_IDLE};
            STEP_DIVINIT: ucode = '{op: OP_DIVINIT, cond: JC_NEVER,     target: STEP_IDLE};
            STEP_DIV:     ucode = '{op: OP_DIV,     cond: JC_DIV_MORE,  target: STEP_DIV};
            STEP_FIN:     ucode = '{op: OP_FIN,     cond: JC_NEVER,     target: STEP_IDLE};
            STEP_EMIT:    ucode = '{op: OP_EMIT,    cond: JC_OUT_BUSY,  target: STEP_EMIT};
            STEP_RETURN:  ucode = '{op: OP_NOP,     cond: JC_ALWAYS,    target: STEP_IDLE};
            STEP_WRITE:   ucode = '{op: OP_WRITE,   cond: JC_ALWAYS,    target: STEP_IDLE};
            default:      ucode = '{op: OP_NOP,     cond: JC_ALWAYS,    target: STEP_IDLE};
        endcase
    endfunction

    // Built-in default curve.
    function automatic t_bp default_bp(input logic [TAB_IDX_W-1:0] idx);
        case (idx)
            5'd0:    default_bp = {12'd0,    8'hff};
            5'd1:    default_bp = {12'd1,    8'hee};
            5'd2:    default_bp = {12'd2,    8'he8};
            5'd3:    default_bp = {12'd3,    8'he6};
            5'd4:    default_bp = {12'd4,    8'he5};
            5'd5:    default_bp = {12'd6,    8'he4};
            5'd6:    default_bp = {12'd10,   8'he0};
            5'd7:    default_bp = {12'd20,   8'hd5};
            5'd8:    default_bp = {12'd30,   8'hce};
            5'd9:    default_bp = {12'd45,   8'hc6};
            5'd10:   default_bp = {12'd70,   8'hb7};
            5'd11:   default_bp = {12'd100,  8'had};
            5'd12:   default_bp = {12'd150,  8'ha0};
            5'd13:   default_bp = {12'd227,  8'h8a};
            5'd14:   default_bp = {12'd300,  8'h80};
            5'd15:   default_bp = {12'd400,  8'h6e};
            5'd16:   default_bp = {12'd500,  8'h5b};
            5'd17:   default_bp = {12'd600,  8'h50};
            5'd18:   default_bp = {12'd800,  8'h38};
            5'd19:   default_bp = {12'd1023, 8'h18};
            default: default_bp = {12'd1023, 8'h18};
        endcase
    endfunction

    // Built-in alternate curve.
    function automatic t_bp alt_bp(input logic [TAB_IDX_W-1:0] idx);
        case (idx)
            5'd0:    alt_bp = {12'd0,   8'hff};
            5'd1:    alt_bp = {12'd1,   8'he0};
            5'd2:    alt_bp = {12'd2,   8'hd6};
            5'd3:    alt_bp = {12'd3,   8'hd5};
            5'd4:    alt_bp = {12'd4,   8'hcf};
            5'd5:    alt_bp = {12'd5,   8'hcb};
            5'd6:    alt_bp = {12'd6,   8'hc9};
            5'd7:    alt_bp = {12'd8,   8'hc5};
            5'd8:    alt_bp = {12'd10,  8'hc1};
            5'd9:    alt_bp = {12'd15,  8'hb6};
            5'd10:   alt_bp = {12'd20,  8'hac};
            5'd11:   alt_bp = {12'd30,  8'h9d};
            5'd12:   alt_bp = {12'd45,  8'h82};
            5'd13:   alt_bp = {12'd70,  8'h6c};
            5'd14:   alt_bp = {12'd100, 8'h56};
            5'd15:   alt_bp = {12'd120, 8'h47};
            5'd16:   alt_bp = {12'd140, 8'h3a};
            5'd17:   alt_bp = {12'd160, 8'h2f};
            5'd18:   alt_bp = {12'd180, 8'h22};
            5'd19:   alt_bp = {12'd200, 8'h16};
            5'd20:   alt_bp = {12'd220, 8'h0e};
            5'd21:   alt_bp = {12'd240, 8'h06};
            5'd22:   alt_bp = {12'd260, 8'h00};
            default: alt_bp = {12'd260, 8'h00};
        endcase
    endfunction

endpackage

@@ design/bldim_in_if.sv @@
// Input channel: one conversion or custom table write per item.
interface bldim_in_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   cmd;
    logic [bldim_pkg::LEVEL_BITS-1:0]       level;
    logic [bldim_pkg::ENTRY_IDX_W-1:0]      entry_index;
    logic [bldim_pkg::LEVEL_BITS-1:0]       entry_level;
    logic [bldim_pkg::ALPHA_W-1:0]          entry_alpha;

    modport source (output valid, output cmd, output level, output entry_index,
                    output entry_level, output entry_alpha, input ready);
    modport sink   (input valid, input cmd, input level, input entry_index,
                    input entry_level, input entry_alpha, output ready);
endinterface

@@ design/bldim_out_if.sv @@
// Output channel: one alpha result per converted item.
interface bldim_out_if;
    logic                          valid;
    logic                          ready;
    logic [bldim_pkg::ALPHA_W-1:0] alpha;
    logic                          dither_on;

    modport source (output valid, output alpha, output dither_on, input ready);
    modport sink   (input valid, input alpha, input dither_on, output ready);
endinterface

@@ design/bldim_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
module bldim_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/bldim_seq.sv @@
// Microprogram sequencer: step counter, control ROM and jump logic.
module bldim_seq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  bldim_pkg::t_stat     i_stat,
    output bldim_pkg::t_ctrl     o_ctrl,
    output bldim_pkg::t_step     o_pc
);

    bldim_pkg::t_step  r_pc;
    bldim_pkg::t_step  n_pc;
    bldim_pkg::t_uword w_word;
    logic              w_take;

    assign w_word = bldim_pkg::ucode(r_pc);

    // Evaluate the jump condition of the current control word.
    always_comb begin
        unique case (w_word.cond)
            bldim_pkg::JC_NEVER:     w_take = 1'b0;
            bldim_pkg::JC_ALWAYS:    w_take = 1'b1;
            bldim_pkg::JC_NO_ACCEPT: w_take = !i_stat.accept;
            bldim_pkg::JC_WRITE:     w_take = i_stat.is_write;
            bldim_pkg::JC_DIRECT:    w_take = i_stat.direct;
            bldim_pkg::JC_MORE:      w_take = i_stat.more;
            bldim_pkg::JC_CLAMP:     w_take = i_stat.clamp;
            bldim_pkg::JC_DIV_MORE:  w_take = i_stat.div_more;
            bldim_pkg::JC_OUT_BUSY:  w_take = i_stat.out_busy;
            default:                 w_take = 1'b1;
        endcase
        n_pc = w_take ? w_word.target : r_pc + bldim_pkg::t_step'(1);
    end

    // Step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= bldim_pkg::STEP_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_ctrl.op       = w_word.op;
    assign o_ctrl.in_ready = (w_word.op == bldim_pkg::OP_IDLE);
    assign o_pc            = r_pc;

endmodule

@@ design/bldim_dp.sv @@
// Datapath: configuration registers, table walk, interpolation divider and output register.
module bldim_dp #(
    parameter int TABLE_DEPTH = bldim_pkg::TABLE_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [bldim_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [bldim_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  bldim_pkg::t_ctrl                    i_ctrl,
    output bldim_pkg::t_stat                    o_stat,
    bldim_in_if.sink                            i_in,
    bldim_out_if.source                         o_out
);

    localparam int MAX_N  = (TABLE_DEPTH > bldim_pkg::ALT_COUNT) ? TABLE_DEPTH
                                                                  : bldim_pkg::ALT_COUNT;
    localparam int CNT_W  = $clog2(MAX_N + 1);
    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int LB     = bldim_pkg::LEVEL_BITS;
    localparam int AB     = bldim_pkg::ALPHA_W;

    // Configuration registers.
    logic [AB-1:0]                    r_cfg_override;
    logic                             r_cfg_boost;
    logic                             r_cfg_primary;
    logic                             r_cfg_fix_pend;
    bldim_pkg::t_level                r_cfg_fix_level;
    bldim_pkg::t_level                r_cfg_last;
    logic [bldim_pkg::ENTRIES_W-1:0]  r_cfg_entries;
    logic [AB-1:0]                    r_cfg_dither;

    // Latched item.
    logic                                 r_cmd;
    bldim_pkg::t_level                    r_level;
    logic [bldim_pkg::ENTRY_IDX_W-1:0]    r_entry_idx;
    bldim_pkg::t_level                    r_entry_level;
    bldim_pkg::t_alpha                    r_entry_alpha;

    // Walk and interpolation state.
    bldim_pkg::t_level   r_lvl;
    bldim_pkg::t_tab     r_tsel;
    logic [CNT_W-1:0]    r_cnt;
    logic [CNT_W-1:0]    r_idx;
    bldim_pkg::t_bp      r_tdat;
    bldim_pkg::t_level   r_l0;
    bldim_pkg::t_alpha   r_a0;
    bldim_pkg::t_level   r_l1;
    bldim_pkg::t_alpha   r_a1;
    logic                r_hit;
    logic                r_first;
    logic                r_last;
    logic                r_neg;
    logic [LB+AB-1:0]    r_prod;
    bldim_pkg::t_level   r_den;
    bldim_pkg::t_level   r_rem;
    bldim_pkg::t_alpha   r_quo;
    logic [bldim_pkg::DCNT_W-1:0] r_dcnt;
    bldim_pkg::t_alpha   r_res;

    // Output register.
    logic                r_out_valid;
    bldim_pkg::t_alpha   r_out_alpha;
    logic                r_out_dither;

    logic                w_accept;
    bldim_pkg::t_level   w_lvl_sel;
    bldim_pkg::t_level   w_lvl_use;
    logic [CNT_W-1:0]    w_cnt_cust;
    logic [bldim_pkg::BP_W-1:0] w_ram_rdata;
    bldim_pkg::t_bp      w_rd;
    logic                w_hit;
    logic                w_last;
    bldim_pkg::t_alpha   w_adiff;
    bldim_pkg::t_level   w_ldiff;
    logic [LB:0]         w_trial;
    logic                w_ge;
    logic                w_out_busy;
    logic                w_emit;
    logic                w_ram_we;

    assign w_accept   = i_in.valid && i_ctrl.in_ready;
    assign i_in.ready = i_ctrl.in_ready;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_override  <= '0;
            r_cfg_boost     <= 1'b0;
            r_cfg_primary   <= 1'b0;
            r_cfg_fix_pend  <= 1'b0;
            r_cfg_fix_level <= '0;
            r_cfg_last      <= '0;
            r_cfg_entries   <= '0;
            r_cfg_dither    <= '0;
        end else if (i_cfg_we) begin
            unique case (bldim_pkg::t_cfg'(i_cfg_idx))
                bldim_pkg::CFG_OVERRIDE:  r_cfg_override  <= i_cfg_data[AB-1:0];
                bldim_pkg::CFG_BOOST:     r_cfg_boost     <= i_cfg_data[0];
                bldim_pkg::CFG_PRIMARY:   r_cfg_primary   <= i_cfg_data[0];
                bldim_pkg::CFG_FIX_PEND:  r_cfg_fix_pend  <= i_cfg_data[0];
                bldim_pkg::CFG_FIX_LEVEL: r_cfg_fix_level <= i_cfg_data[LB-1:0];
                bldim_pkg::CFG_LAST:      r_cfg_last      <= i_cfg_data[LB-1:0];
                bldim_pkg::CFG_ENTRIES:   r_cfg_entries   <= i_cfg_data[bldim_pkg::ENTRIES_W-1:0];
                bldim_pkg::CFG_DITHER:    r_cfg_dither    <= i_cfg_data[AB-1:0];
                default:                  r_cfg_dither    <= r_cfg_dither;
            endcase
        end
    end

    // Level selection with substitution of levels 0 and 1; custom entry count clamped to the depth.
    always_comb begin
        w_lvl_sel = r_cfg_fix_pend ? r_cfg_fix_level : r_level;
        w_lvl_use = (w_lvl_sel <= bldim_pkg::t_level'(1)) ? r_cfg_last : w_lvl_sel;
        if (int'(r_cfg_entries) > TABLE_DEPTH) begin
            w_cnt_cust = CNT_W'(TABLE_DEPTH);
        end else begin
            w_cnt_cust = CNT_W'(r_cfg_entries);
        end
    end

    // Custom table storage.
    assign w_ram_we = (i_ctrl.op == bldim_pkg::OP_WRITE) && (int'(r_entry_idx) < TABLE_DEPTH);

    bldim_ram #(
        .WIDTH (bldim_pkg::BP_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (ADDR_W'(r_entry_idx)),
        .i_wdata ({r_entry_level, r_entry_alpha}),
        .i_re    (i_ctrl.op == bldim_pkg::OP_READ),
        .i_raddr (r_idx[ADDR_W-1:0]),
        .o_rdata (w_ram_rdata)
    );

    // Breakpoint compare and divider trial subtraction.
    always_comb begin
        w_rd    = (r_tsel == bldim_pkg::TAB_CUST) ? bldim_pkg::t_bp'(w_ram_rdata) : r_tdat;
        w_hit   = (w_rd.lvl >= r_lvl);
        w_last  = ((r_idx + CNT_W'(1)) == r_cnt);
        w_adiff = (r_a1 < r_a0) ? (r_a0 - r_a1) : (r_a1 - r_a0);
        w_ldiff = r_lvl - r_l0;
        w_trial = {r_rem, r_quo[AB-1]};
        w_ge    = (w_trial >= {1'b0, r_den});
    end

    assign w_out_busy = r_out_valid && !o_out.ready;
    assign w_emit     = (i_ctrl.op == bldim_pkg::OP_EMIT) && !w_out_busy;

    // Item latch and working registers, driven by the current operation.
    always_ff @(posedge i_clk) begin
        unique case (i_ctrl.op)
            bldim_pkg::OP_IDLE: begin
                if (w_accept) begin
                    r_cmd         <= i_in.cmd;
                    r_level       <= i_in.level;
                    r_entry_idx   <= i_in.entry_index;
                    r_entry_level <= i_in.entry_level;
                    r_entry_alpha <= i_in.entry_alpha;
                end
            end
            bldim_pkg::OP_LOAD: begin
                r_res <= r_cfg_override;
                r_lvl <= w_lvl_use;
                r_idx <= '0;
                if (!r_cfg_primary) begin
                    r_tsel <= bldim_pkg::TAB_ALT;
                    r_cnt  <= CNT_W'(bldim_pkg::ALT_COUNT);
                end else if (r_cfg_entries == '0) begin
                    r_tsel <= bldim_pkg::TAB_DEF;
                    r_cnt  <= CNT_W'(bldim_pkg::DEFAULT_COUNT);
                end else begin
                    r_tsel <= bldim_pkg::TAB_CUST;
                    r_cnt  <= w_cnt_cust;
                end
            end
            bldim_pkg::OP_READ: begin
                if (r_tsel == bldim_pkg::TAB_DEF) begin
                    r_tdat <= bldim_pkg::default_bp(r_idx[bldim_pkg::TAB_IDX_W-1:0]);
                end else begin
                    r_tdat <= bldim_pkg::alt_bp(r_idx[bldim_pkg::TAB_IDX_W-1:0]);
                end
            end
            bldim_pkg::OP_CHECK: begin
                r_hit   <= w_hit;
                r_first <= (r_idx == '0);
                r_last  <= w_last;
                r_res   <= w_rd.a;
                r_l1    <= w_rd.lvl;
                r_a1    <= w_rd.a;
                // A breakpoint below the level becomes the lower bracket.
                if (!w_hit) begin
                    r_l0  <= w_rd.lvl;
                    r_a0  <= w_rd.a;
                    r_idx <= r_idx + CNT_W'(1);
                end
            end
            bldim_pkg::OP_MUL: begin
                r_neg  <= (r_a1 < r_a0);
                r_prod <= w_adiff * w_ldiff;
                r_den  <= r_l1 - r_l0;
            end
            bldim_pkg::OP_DIVINIT: begin
                // The quotient fits eight bits, so the upper part is already below the divisor.
                r_rem  <= r_prod[LB+AB-1:AB];
                r_quo  <= r_prod[AB-1:0];
                r_dcnt <= '0;
            end
            bldim_pkg::OP_DIV: begin
                r_rem  <= w_ge ? LB'(w_trial - {1'b0, r_den}) : w_trial[LB-1:0];
                r_quo  <= {r_quo[AB-2:0], w_ge};
                r_dcnt <= r_dcnt + bldim_pkg::DCNT_W'(1);
            end
            bldim_pkg::OP_FIN: begin
                r_res <= r_neg ? (r_a0 - r_quo) : (r_a0 + r_quo);
            end
            default: begin
                r_res <= r_res;
            end
        endcase
    end

    // Output register: holds a result while the next item is taken in.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_alpha  <= r_res;
            r_out_dither <= (r_res >= r_cfg_dither);
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.alpha     = r_out_alpha;
    assign o_out.dither_on = r_out_dither;

    // Status for the sequencer.
    assign o_stat.accept   = w_accept;
    assign o_stat.is_write = r_cmd;
    assign o_stat.direct   = (r_cfg_override != '0) || r_cfg_boost;
    assign o_stat.more     = !w_hit && !w_last;
    assign o_stat.clamp    = (r_hit && r_first) || (!r_hit && r_last);
    assign o_stat.div_more = (r_dcnt != {bldim_pkg::DCNT_W{1'b1}});
    assign o_stat.out_busy = w_out_busy;

endmodule

@@ design/backlight_to_dim_alpha.sv @@
// Backlight level to dim layer alpha converter, top level.
// One item at a time, each finished before the next is taken: a table write, an override or
// boost result, a clamped walk over the breakpoints, or an interpolated walk with an eight-step
// divider. A result is registered in the emit step, and the return step comes before the next
// item can be taken; a stalled output holds the emit step. Reset clears the configuration and
// output valid; the custom table has none.
module backlight_to_dim_alpha #(
    parameter int TABLE_DEPTH = bldim_pkg::TABLE_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [bldim_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bldim_pkg::CFG_DATA_W-1:0] i_cfg_data,
    bldim_in_if.sink                         i_in,
    bldim_out_if.source                      o_out
);

    bldim_pkg::t_ctrl w_ctrl;
    bldim_pkg::t_stat w_stat;
    bldim_pkg::t_step w_pc;

    // Control sequencer.
    bldim_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_ctrl  (w_ctrl),
        .o_pc    (w_pc)
    );

    // Datapath.
    bldim_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_ctrl     (w_ctrl),
        .o_stat     (w_stat),
        .i_in       (i_in),
        .o_out      (o_out)
    );

`ifndef NO_ASSERTIONS
    // Once an item is taken the block is busy for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input ready while previous item still in work");

    // A result only appears from the emit step.
    a_emit_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(w_pc == bldim_pkg::STEP_EMIT))
        else $error("result raised outside the emit step");

    // A table write item goes straight to the write step.
    a_write_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.cmd) |-> ##2 (w_pc == bldim_pkg::STEP_WRITE))
        else $error("write item did not reach the write step");
`endif

endmodule

@@ dv/dim_alpha_tb_pkg.sv @@
// Command codes shared by the dim alpha testbench files.
`timescale 1ns / 1ps
package dim_alpha_tb_pkg;

    // Meaning of the cmd field of an input item.
    typedef enum logic {
        CMD_CONVERT     = 1'b0,
        CMD_TABLE_WRITE = 1'b1
    } dim_cmd_t;

endpackage

@@ dv/dim_alpha_checker.sv @@
// Checker for the dim alpha converter: predicts every alpha result and compares it in order.
`timescale 1ns / 1ps
module dim_alpha_checker
    import bldim_pkg::*;
    import dim_alpha_tb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    bldim_in_if                   i_in_mon,
    bldim_out_if                  i_out_mon,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_result_count
);

    localparam int CUSTOM_DEPTH = 32;
    localparam int MAX_REPORTS  = 40;

    // Built-in curves, breakpoint levels and the alpha at each.
    localparam int DEF_N = 20;
    localparam int DEF_LVL [DEF_N] = '{
        0, 1, 2, 3, 4, 6, 10, 20, 30, 45, 70, 100, 150, 227, 300, 400, 500, 600, 800, 1023
    };
    localparam int DEF_ALPHA [DEF_N] = '{
        'hff, 'hee, 'he8, 'he6, 'he5, 'he4, 'he0, 'hd5, 'hce, 'hc6,
        'hb7, 'had, 'ha0, 'h8a, 'h80, 'h6e, 'h5b, 'h50, 'h38, 'h18
    };
    localparam int ALT_N = 23;
    localparam int ALT_LVL [ALT_N] = '{
        0, 1, 2, 3, 4, 5, 6, 8, 10, 15, 20, 30, 45, 70, 100, 120, 140, 160, 180, 200,
        220, 240, 260
    };
    localparam int ALT_ALPHA [ALT_N] = '{
        'hff, 'he0, 'hd6, 'hd5, 'hcf, 'hcb, 'hc9, 'hc5, 'hc1, 'hb6, 'hac, 'h9d,
        'h82, 'h6c, 'h56, 'h47, 'h3a, 'h2f, 'h22, 'h16, 'h0e, 'h06, 'h00
    };

    typedef struct packed {
        t_alpha alpha;
        logic   dither_on;
    } dim_result_t;

    // Local copy of the registers and of the custom curve.
    t_alpha                ovr_alpha;
    logic                  boost_on;
    logic                  primary_sel;
    logic                  fixed_pend;
    t_level                fixed_lvl;
    t_level                last_lvl;
    logic [ENTRIES_W-1:0]  n_custom;
    t_alpha                dither_thr;
    t_level                cust_lvl [CUSTOM_DEPTH];
    t_alpha                cust_alpha [CUSTOM_DEPTH];

    dim_result_t expected_alpha_q [$];
    int          fail_total   = 0;
    int          result_total = 0;

    task automatic report_mismatch(input string msg);
        if (fail_total < MAX_REPORTS) begin
            $display("[%0t] MISMATCH: %s", $time, msg);
        end
        fail_total++;
    endtask

    // Breakpoint k of the selected curve.
    function automatic void breakpoint(input t_tab tab, input int k, output int lvl,
                                       output int a);
        case (tab)
            TAB_ALT: begin
                lvl = ALT_LVL[k];
                a   = ALT_ALPHA[k];
            end
            TAB_DEF: begin
                lvl = DEF_LVL[k];
                a   = DEF_ALPHA[k];
            end
            default: begin
                lvl = int'(cust_lvl[k]);
                a   = int'(cust_alpha[k]);
            end
        endcase
    endfunction

    // First breakpoint at or above the level, clamped at both ends, truncating interpolation.
    function automatic int walk_curve(input t_tab tab, input int count, input int lvl);
        int hit;
        int lo_l, lo_a, hi_l, hi_a;
        int den, r;
        hit = count;
        for (int k = count - 1; k >= 0; k--) begin
            breakpoint(tab, k, hi_l, hi_a);
            if (hi_l >= lvl) hit = k;
        end
        if (hit == count) begin
            breakpoint(tab, count - 1, hi_l, hi_a);
            return hi_a;
        end
        breakpoint(tab, hit, hi_l, hi_a);
        if (hit == 0) return hi_a;
        breakpoint(tab, hit - 1, lo_l, lo_a);
        den = hi_l - lo_l;
        if (den <= 0) return hi_a;
        r = lo_a + (hi_a - lo_a) * (lvl - lo_l) / den;
        if (r < 0) r = 0;
        if (r > 255) r = 255;
        return r;
    endfunction

    // Override first, then boost, then the level substitutions and the table choice.
    function automatic t_alpha predict_alpha(input int req_lvl);
        int lvl;
        int n;
        if (ovr_alpha != '0) return ovr_alpha;
        if (boost_on) return '0;
        lvl = fixed_pend ? int'(fixed_lvl) : req_lvl;
        if (lvl <= 1) lvl = int'(last_lvl);
        if (!primary_sel) return t_alpha'(walk_curve(TAB_ALT, ALT_N, lvl));
        n = (int'(n_custom) > CUSTOM_DEPTH) ? CUSTOM_DEPTH : int'(n_custom);
        if (n == 0) return t_alpha'(walk_curve(TAB_DEF, DEF_N, lvl));
        return t_alpha'(walk_curve(TAB_CUST, n, lvl));
    endfunction

    // Items are predicted with the settings in force before this edge's register write.
    always @(posedge i_clk) begin
        dim_result_t want;
        dim_result_t got;
        if (!i_rst_n) begin
            ovr_alpha   = '0;
            boost_on    = 1'b0;
            primary_sel = 1'b0;
            fixed_pend  = 1'b0;
            fixed_lvl   = '0;
            last_lvl    = '0;
            n_custom    = '0;
            dither_thr  = '0;
            for (int k = 0; k < CUSTOM_DEPTH; k++) begin
                cust_lvl[k]   = '0;
                cust_alpha[k] = '0;
            end
            expected_alpha_q.delete();
        end else begin
            if (i_in_mon.valid && i_in_mon.ready) begin
                if (i_in_mon.cmd == CMD_TABLE_WRITE) begin
                    cust_lvl[i_in_mon.entry_index]   = i_in_mon.entry_level;
                    cust_alpha[i_in_mon.entry_index] = i_in_mon.entry_alpha;
                end else begin
                    want.alpha     = predict_alpha(int'(i_in_mon.level));
                    want.dither_on = (want.alpha >= dither_thr);
                    expected_alpha_q.push_back(want);
                end
            end

            if (i_out_mon.valid && i_out_mon.ready) begin
                result_total++;
                got.alpha     = i_out_mon.alpha;
                got.dither_on = i_out_mon.dither_on;
                if (expected_alpha_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result alpha=%0h dither_on=%b",
                                              got.alpha, got.dither_on));
                end else begin
                    want = expected_alpha_q.pop_front();
                    if (got.alpha !== want.alpha) begin
                        report_mismatch($sformatf("result %0d: alpha %0h, expected %0h",
                                                  result_total, got.alpha, want.alpha));
                    end
                    if (got.dither_on !== want.dither_on) begin
                        report_mismatch($sformatf("result %0d: dither_on %b, expected %b",
                                                  result_total, got.dither_on,
                                                  want.dither_on));
                    end
                end
            end

            if (i_cfg_we) begin
                case (t_cfg'(i_cfg_idx))
                    CFG_OVERRIDE:  ovr_alpha   = i_cfg_data[ALPHA_W-1:0];
                    CFG_BOOST:     boost_on    = i_cfg_data[0];
                    CFG_PRIMARY:   primary_sel = i_cfg_data[0];
                    CFG_FIX_PEND:  fixed_pend  = i_cfg_data[0];
                    CFG_FIX_LEVEL: fixed_lvl   = i_cfg_data[LEVEL_BITS-1:0];
                    CFG_LAST:      last_lvl    = i_cfg_data[LEVEL_BITS-1:0];
                    CFG_ENTRIES:   n_custom    = i_cfg_data[ENTRIES_W-1:0];
                    CFG_DITHER:    dither_thr  = i_cfg_data[ALPHA_W-1:0];
                    default: ;
                endcase
            end
        end
        o_pending      <= expected_alpha_q.size();
        o_fail_count   <= fail_total;
        o_result_count <= result_total;
    end

endmodule

@@ dv/tb_backlight_to_dim_alpha.sv @@
// Testbench top for the dim alpha converter: clock, reset, stimulus, idling and verdict.
`timescale 1ns / 1ps
module tb_backlight_to_dim_alpha;
    import bldim_pkg::*;
    import dim_alpha_tb_pkg::*;

    localparam int CLK_HALF        = 4;
    localparam int RESET_CYCLES    = 6;
    localparam int RANDOM_PHASES   = 20;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int CUSTOM_DEPTH    = 32;
    localparam int SETTLE_CYCLES   = 8;
    localparam int TAIL_CYCLES     = 100;
    localparam int CYCLE_LIMIT     = 2_000_000;

    typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    typedef struct {
        int override_a;
        int boost;
        int primary;
        int fixed_pend;
        int fixed_lvl;
        int last_lvl;
        int entries;
        int dither;
    } dim_setting_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    int fail_count;
    int pending;
    int result_count;
    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int items_sent     = 0;
    int table_writes   = 0;
    int settings_used  = 0;

    bldim_in_if  in_ch ();
    bldim_out_if out_ch ();

    backlight_to_dim_alpha u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    dim_alpha_checker u_chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .i_in_mon       (in_ch),
        .i_out_mon      (out_ch),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // Cycle counter and the timeout that it drives.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
        $display("== FAIL ==");
        $finish;
    end

    // Result side: ready is withdrawn at random at the current stall rate.
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Offer one item after an optional random gap and hold it until it is taken.
    task automatic send_item(input dim_cmd_t cmd, input int lvl, input int idx,
                             input int e_lvl, input int e_alpha);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.cmd         <= cmd;
        in_ch.level       <= t_level'(lvl);
        in_ch.entry_index <= ENTRY_IDX_W'(idx);
        in_ch.entry_level <= t_level'(e_lvl);
        in_ch.entry_alpha <= t_alpha'(e_alpha);
        do @(posedge i_clk); while (!in_ch.ready);
        items_sent++;
        if (cmd == CMD_TABLE_WRITE) table_writes++;
    endtask

    // The table fields of a conversion are don't-care and are randomised.
    task automatic send_convert(input int lvl);
        send_item(CMD_CONVERT, lvl, $urandom_range(CUSTOM_DEPTH - 1), $urandom_range(4095),
                  $urandom_range(255));
    endtask

    task automatic send_write(input int idx, input int e_lvl, input int e_alpha);
        send_item(CMD_TABLE_WRITE, $urandom_range(4095), idx, e_lvl, e_alpha);
    endtask

    // Wait until every expected result is in and a trailing table write has finished.
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg idx, input int val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= CFG_DATA_W'(val);
        @(posedge i_clk);
    endtask

    // Registers are only written with the block idle.
    task automatic configure(input dim_setting_t s);
        settle();
        write_reg(CFG_OVERRIDE, s.override_a);
        write_reg(CFG_BOOST, s.boost);
        write_reg(CFG_PRIMARY, s.primary);
        write_reg(CFG_FIX_PEND, s.fixed_pend);
        write_reg(CFG_FIX_LEVEL, s.fixed_lvl);
        write_reg(CFG_LAST, s.last_lvl);
        write_reg(CFG_ENTRIES, s.entries);
        write_reg(CFG_DITHER, s.dither);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    initial begin
        dim_setting_t s;
        idle_mode_t   mode;
        int           table_lvl [CUSTOM_DEPTH];
        int           table_n;
        int           span;
        int           pick;
        int           lvl;
        int           a;
        int           b;

        i_rst_n           <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_idx           <= CFG_OVERRIDE;
        cfg_data          <= '0;
        in_ch.valid       <= 1'b0;
        in_ch.cmd         <= CMD_CONVERT;
        in_ch.level       <= '0;
        in_ch.entry_index <= '0;
        in_ch.entry_level <= '0;
        in_ch.entry_alpha <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: alternate curve, both ends, low levels replaced by last level.
        s = '{default: 0};
        send_convert(0);
        send_convert(1);
        send_convert(2);
        send_convert(130);
        send_convert(260);
        send_convert(4095);

        // Override wins over boost, with the dither threshold at its top.
        s.override_a = 255;
        s.boost      = 1;
        s.dither     = 255;
        configure(s);
        send_convert(5);

        // Boost alone forces alpha to zero, which still meets a zero threshold.
        s.override_a = 0;
        s.dither     = 0;
        configure(s);
        send_convert(4095);

        // Built-in default curve with the fixed level pending at the top of its range.
        s.boost      = 0;
        s.primary    = 1;
        s.fixed_pend = 1;
        s.fixed_lvl  = 4095;
        s.dither     = 128;
        configure(s);
        send_convert(7);

        // A fixed level of 1 falls back to the last level.
        s.fixed_lvl = 1;
        s.last_lvl  = 1023;
        configure(s);
        send_convert(2000);

        s.fixed_pend = 0;
        configure(s);
        send_convert(0);
        send_convert(3);
        send_convert(228);
        send_convert(1024);

        // Small custom curve loaded out of order.
        send_write(0, 100, 'h10);
        send_write(1, 50, 'hf0);
        send_write(2, 4095, 'h00);
        send_write(3, 200, 'h80);
        s.entries = 4;
        configure(s);
        send_convert(75);
        send_convert(150);
        send_convert(4095);
        send_convert(1);

        // Random phases, each with its own settings and idling pattern.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            mode = idle_mode_t'(ph % 4);
            case (mode)
                IDLE_NONE: begin
                    send_idle_pct  <= 0;
                    recv_stall_pct <= 0;
                end
                IDLE_SEND: begin
                    send_idle_pct  <= 66;
                    recv_stall_pct <= 0;
                end
                IDLE_RECV: begin
                    send_idle_pct  <= 0;
                    recv_stall_pct <= 66;
                end
                default: begin
                    send_idle_pct  <= 36;
                    recv_stall_pct <= 36;
                end
            endcase

            s.override_a = ($urandom_range(99) < 15) ? $urandom_range(255, 1) : 0;
            s.boost      = ($urandom_range(99) < 15);
            s.primary    = ($urandom_range(99) < 75);
            s.fixed_pend = ($urandom_range(99) < 15);
            s.fixed_lvl  = $urandom_range(4095);
            case ($urandom_range(4))
                0:       s.last_lvl = 0;
                1:       s.last_lvl = 1;
                2:       s.last_lvl = 4095;
                default: s.last_lvl = $urandom_range(4095);
            endcase
            pick = $urandom_range(99);
            if (pick < 20) s.entries = 0;
            else if (pick < 65) s.entries = $urandom_range(8, 1);
            else if (pick < 90) s.entries = $urandom_range(CUSTOM_DEPTH, 9);
            else s.entries = $urandom_range(63, CUSTOM_DEPTH + 1);
            case ($urandom_range(3))
                0:       s.dither = 0;
                1:       s.dither = 255;
                default: s.dither = $urandom_range(255);
            endcase

            // The first two phases take the register extremes on the custom curve.
            if (ph == 0) begin
                s = '{override_a: 0, boost: 0, primary: 1, fixed_pend: 0, fixed_lvl: 4095,
                      last_lvl: 4095, entries: 63, dither: 255};
            end else if (ph == 1) begin
                s = '{override_a: 0, boost: 0, primary: 1, fixed_pend: 0, fixed_lvl: 0,
                      last_lvl: 0, entries: 1, dither: 0};
            end

            // Every slot that the walk can reach is loaded before the count is set.
            table_n = (s.entries > CUSTOM_DEPTH) ? CUSTOM_DEPTH : s.entries;
            if (table_n != 0) begin
                span = 4096 / table_n;
                for (int k = 0; k < table_n; k++) begin
                    table_lvl[k] = k * span + $urandom_range(span - 1);
                end
                // Now and then the curve is left out of order.
                if (table_n > 1 && $urandom_range(99) < 20) begin
                    a            = $urandom_range(table_n - 1);
                    b            = $urandom_range(table_n - 1);
                    lvl          = table_lvl[a];
                    table_lvl[a] = table_lvl[b];
                    table_lvl[b] = lvl;
                end
                for (int k = 0; k < table_n; k++) begin
                    send_write(k, table_lvl[k], $urandom_range(255));
                end
            end
            configure(s);

            // Mostly conversions around the breakpoints, with stray table writes.
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                pick = $urandom_range(99);
                if (pick < 10) begin
                    send_write($urandom_range(CUSTOM_DEPTH - 1), $urandom_range(4095),
                               $urandom_range(255));
                end else begin
                    if (pick < 25) lvl = $urandom_range(2);
                    else if (pick < 45) lvl = $urandom_range(300);
                    else if (pick < 65) lvl = $urandom_range(1100);
                    else if (pick < 80 || table_n == 0) lvl = $urandom_range(4095);
                    else begin
                        lvl = table_lvl[$urandom_range(table_n - 1)] + $urandom_range(4) - 2;
                        if (lvl < 0) lvl = 0;
                        if (lvl > 4095) lvl = 4095;
                    end
                    send_convert(lvl);
                end
            end
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Run covered %0d items, %0d of them table writes, over %0d register settings",
                 items_sent, table_writes, settings_used);
        $display("and four idling patterns; %0d results checked in %0d cycles, %0d mismatches.",
                 result_count, cycle_count, fail_count);
        if (pending != 0) begin
            $display("ERROR: %0d expected results never arrived", pending);
        end
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
design/bldim_pkg.sv
design/bldim_in_if.sv
design/bldim_out_if.sv
design/bldim_ram.sv
design/bldim_seq.sv
design/bldim_dp.sv
design/backlight_to_dim_alpha.sv
dv/dim_alpha_tb_pkg.sv
dv/dim_alpha_checker.sv
dv/tb_backlight_to_dim_alpha.sv
